@@ hdl/scrdg_pkg.sv @@
`default_nettype none
package scrdg_pkg;

    localparam int SCREEN_WIDTH    = 240;
    localparam int SCREEN_HEIGHT   = 160;
    localparam int MAX_SPRITE_ROWS = 64;

    localparam logic [31:0] FRAME_BASE_RESET = 32'h0600_0000;

    // Accumulator width for the running line offsets.
    localparam int ACC_W = 22;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SETUP,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic clip;
        logic setup;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic draw;
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/scrdg_ctrl.sv @@
`default_nettype none
module scrdg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output scrdg_pkg::dp_cmd_t        cmd,
    input  wire scrdg_pkg::dp_status_t status
);
    import scrdg_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = status.draw ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/scrdg_datapath.sv @@
`default_nettype none
module scrdg_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scrdg_pkg::dp_cmd_t    cmd,
    output scrdg_pkg::dp_status_t      status,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic signed [10:0]    dest_row,
    input  wire logic signed [10:0]    dest_col,
    input  wire logic [9:0]            src_row,
    input  wire logic [9:0]            src_col,
    input  wire logic [6:0]            sprite_height,
    input  wire logic [7:0]            sprite_width,
    input  wire logic [31:0]           image_base,
    input  wire logic [9:0]            image_pitch,
    output logic [31:0]                source_address,
    output logic [31:0]                dest_address,
    output logic [6:0]                 halfword_count,
    output logic                       last_row
);
    import scrdg_pkg::*;

    localparam logic signed [12:0] SW_S  = 13'(SCREEN_WIDTH);
    localparam logic signed [12:0] SH_S  = 13'(SCREEN_HEIGHT);
    localparam logic [6:0]         MAXR  = 7'(MAX_SPRITE_ROWS);
    localparam logic [10:0]        SW_U  = 11'(SCREEN_WIDTH);

    logic [31:0]        frame_base_reg;

    logic signed [10:0] dest_row_reg;
    logic signed [10:0] dest_col_reg;
    logic [9:0]         src_row_reg;
    logic [9:0]         src_col_reg;
    logic [6:0]         sprite_height_reg;
    logic [7:0]         sprite_width_reg;
    logic [31:0]        image_base_reg;
    logic [9:0]         image_pitch_reg;

    logic signed [12:0] clip_r;
    logic signed [12:0] clip_c;
    logic signed [12:0] clip_sr;
    logic signed [12:0] clip_sc;
    logic signed [12:0] clip_w;
    logic signed [12:0] clip_h;
    logic [6:0]         height_sat;
    logic               clip_draw;

    logic [9:0]         r_reg;
    logic [9:0]         c_reg;
    logic [10:0]        sr_reg;
    logic [10:0]        sc_reg;
    logic [7:0]         w_reg;
    logic               draw_reg;
    logic [6:0]         rows_left_reg;

    logic [ACC_W-1:0]   sacc_reg;
    logic [ACC_W-1:0]   dacc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= FRAME_BASE_RESET;
        end
        else if (cfg_we)
        begin
            frame_base_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dest_row_reg      <= dest_row;
            dest_col_reg      <= dest_col;
            src_row_reg       <= src_row;
            src_col_reg       <= src_col;
            sprite_height_reg <= sprite_height;
            sprite_width_reg  <= sprite_width;
            image_base_reg    <= image_base;
            image_pitch_reg   <= image_pitch;
        end
    end

    // Clip against the left and right edges first, then top and bottom.
    always_comb
    begin
        height_sat = (sprite_height_reg > MAXR) ? MAXR : sprite_height_reg;
        clip_r     = 13'(dest_row_reg);
        clip_c     = 13'(dest_col_reg);
        clip_sr    = signed'({3'b000, src_row_reg});
        clip_sc    = signed'({3'b000, src_col_reg});
        clip_w     = signed'({5'b00000, sprite_width_reg});
        clip_h     = signed'({6'b000000, height_sat});
        clip_draw  = (height_sat != 7'd0) && (sprite_width_reg != 8'd0);

        if (clip_c < 0)
        begin
            if (clip_w + clip_c > 0)
            begin
                clip_sc = clip_sc - clip_c;
                clip_w  = clip_w + clip_c;
                clip_c  = '0;
            end
            else
            begin
                clip_draw = 1'b0;
            end
        end
        if (clip_c + clip_w > SW_S)
        begin
            if (clip_c >= SW_S)
            begin
                clip_draw = 1'b0;
            end
            else
            begin
                clip_w = SW_S - clip_c;
            end
        end
        if (clip_r < 0)
        begin
            if (clip_h + clip_r > 0)
            begin
                clip_sr = clip_sr - clip_r;
                clip_h  = clip_h + clip_r;
                clip_r  = '0;
            end
            else
            begin
                clip_draw = 1'b0;
            end
        end
        if (clip_r + clip_h > SH_S)
        begin
            if (clip_r >= SH_S)
            begin
                clip_draw = 1'b0;
            end
            else
            begin
                clip_h = SH_S - clip_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_reg      <= 1'b0;
            rows_left_reg <= '0;
        end
        else if (cmd.clip)
        begin
            draw_reg      <= clip_draw;
            rows_left_reg <= clip_h[6:0];
        end
        else if (cmd.step)
        begin
            rows_left_reg <= rows_left_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            r_reg  <= clip_r[9:0];
            c_reg  <= clip_c[9:0];
            sr_reg <= clip_sr[10:0];
            sc_reg <= clip_sc[10:0];
            w_reg  <= clip_w[7:0];
        end
    end

    // Line offsets start from one multiply each, then advance by one stride per row.
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            sacc_reg <= ACC_W'(sr_reg) * ACC_W'(image_pitch_reg) + ACC_W'(sc_reg);
            dacc_reg <= ACC_W'(r_reg) * ACC_W'(SW_U) + ACC_W'(c_reg);
        end
        else if (cmd.step)
        begin
            sacc_reg <= sacc_reg + ACC_W'(image_pitch_reg);
            dacc_reg <= dacc_reg + ACC_W'(SW_U);
        end
    end

    assign source_address = image_base_reg + 32'({sacc_reg[ACC_W-1:1], 1'b0});
    assign dest_address   = frame_base_reg + 32'({dacc_reg[ACC_W-1:1], 1'b0});
    assign halfword_count = w_reg[7:1];
    assign last_row       = (rows_left_reg == 7'd1);

    assign status.draw = draw_reg;
    assign status.last = last_row;

endmodule
`default_nettype wire

@@ hdl/sprite_clip_row_descriptor_gen_top.sv @@
// The first row descriptor is valid once the request has passed the clip and setup states.
// Throughput: one descriptor per cycle while out_ready is high; a request of h visible rows
// gives h descriptors, and a request that draws nothing gives none. One request is processed at a time.
// The clip stage and the line offset multiply stage both come before rows issue.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and
// sets frame_base to 0x0600_0000.
`default_nettype none
module sprite_clip_row_descriptor_gen_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [10:0] dest_row,
    input  wire logic signed [10:0] dest_col,
    input  wire logic [9:0]         src_row,
    input  wire logic [9:0]         src_col,
    input  wire logic [6:0]         sprite_height,
    input  wire logic [7:0]         sprite_width,
    input  wire logic [31:0]        image_base,
    input  wire logic [9:0]         image_pitch,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             source_address,
    output logic [31:0]             dest_address,
    output logic [6:0]              halfword_count,
    output logic                    last_row
);
    import scrdg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    scrdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    scrdg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .dest_row       (dest_row),
        .dest_col       (dest_col),
        .src_row        (src_row),
        .src_col        (src_col),
        .sprite_height  (sprite_height),
        .sprite_width   (sprite_width),
        .image_base     (image_base),
        .image_pitch    (image_pitch),
        .source_address (source_address),
        .dest_address   (dest_address),
        .halfword_count (halfword_count),
        .last_row       (last_row)
    );

endmodule
`default_nettype wire

@@ dv/sprite_clip_row_descriptor_gen_top_test.sv @@
module sprite_clip_row_descriptor_gen_top_test;

    import scrdg_pkg::*;

    typedef struct {
        logic signed [10:0] dest_row;
        logic signed [10:0] dest_col;
        logic [9:0]         src_row;
        logic [9:0]         src_col;
        logic [6:0]         height;
        logic [7:0]         width;
        logic [31:0]        base;
        logic [9:0]         pitch;
    } blit_req_t;

    typedef struct {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [6:0]  count;
        logic        last;
    } row_desc_t;

    class blit_row_board;
        row_desc_t   rows_due[$];
        logic [31:0] frame_base;
        int          errors;

        function new();
            frame_base = FRAME_BASE_RESET;
            errors = 0;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void plan_rows(blit_req_t q);
            int        r;
            int        c;
            int        sr;
            int        sc;
            int        h;
            int        w;
            int        soff;
            int        doff;
            bit        draw;
            row_desc_t d;
            r = q.dest_row;
            c = q.dest_col;
            sr = int'(q.src_row);
            sc = int'(q.src_col);
            h = int'(q.height);
            w = int'(q.width);
            if (h > MAX_SPRITE_ROWS)
                h = MAX_SPRITE_ROWS;
            draw = (h > 0) && (w > 0);
            if (c < 0)
            begin
                if (w + c > 0)
                begin
                    sc -= c;
                    w += c;
                    c = 0;
                end
                else
                    draw = 1'b0;
            end
            if (c + w > SCREEN_WIDTH)
            begin
                if (c >= SCREEN_WIDTH)
                    draw = 1'b0;
                else
                    w = SCREEN_WIDTH - c;
            end
            if (r < 0)
            begin
                if (h + r > 0)
                begin
                    sr -= r;
                    h += r;
                    r = 0;
                end
                else
                    draw = 1'b0;
            end
            if (r + h > SCREEN_HEIGHT)
            begin
                if (r >= SCREEN_HEIGHT)
                    draw = 1'b0;
                else
                    h = SCREEN_HEIGHT - r;
            end
            if (!draw)
                return;
            for (int k = 0; k < h; k++)
            begin
                soff = ((sr + k) * int'(q.pitch) + sc) >> 1;
                doff = (c + (r + k) * SCREEN_WIDTH) >> 1;
                d.src_addr = q.base + 32'(2 * soff);
                d.dst_addr = frame_base + 32'(2 * doff);
                d.count = 7'(w >> 1);
                d.last = (k == h - 1);
                rows_due.push_back(d);
            end
        endfunction

        function void check_row(logic [31:0] sa, logic [31:0] da, logic [6:0] cnt, logic lr);
            row_desc_t e;
            if (rows_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected row descriptor: src=%h dst=%h count=%0d last=%0b",
                             sa, da, cnt, lr);
            end
            else
            begin
                e = rows_due.pop_front();
                if (e.src_addr !== sa || e.dst_addr !== da || e.count !== cnt || e.last !== lr)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected src=%h dst=%h count=%0d last=%0b, got src=%h dst=%h count=%0d last=%0b",
                                 e.src_addr, e.dst_addr, e.count, e.last, sa, da, cnt, lr);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [10:0] dest_row;
    logic signed [10:0] dest_col;
    logic [9:0]         src_row;
    logic [9:0]         src_col;
    logic [6:0]         sprite_height;
    logic [7:0]         sprite_width;
    logic [31:0]        image_base;
    logic [9:0]         image_pitch;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        source_address;
    logic [31:0]        dest_address;
    logic [6:0]         halfword_count;
    logic               last_row;

    blit_row_board board;
    int            ready_stall_pct = 0;
    int            hold_requests = 0;

    sprite_clip_row_descriptor_gen_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .dest_row       (dest_row),
        .dest_col       (dest_col),
        .src_row        (src_row),
        .src_col        (src_col),
        .sprite_height  (sprite_height),
        .sprite_width   (sprite_width),
        .image_base     (image_base),
        .image_pitch    (image_pitch),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .source_address (source_address),
        .dest_address   (dest_address),
        .halfword_count (halfword_count),
        .last_row       (last_row)
    );

    always #6 clk = ~clk;

    function automatic blit_req_t make_blit(int r, int c, int sr, int sc, int h, int w,
                                            logic [31:0] base, int pitch);
        blit_req_t q;
        q.dest_row = 11'(r);
        q.dest_col = 11'(c);
        q.src_row = 10'(sr);
        q.src_col = 10'(sc);
        q.height = 7'(h);
        q.width = 8'(w);
        q.base = base;
        q.pitch = 10'(pitch);
        return q;
    endfunction

    function automatic blit_req_t random_blit();
        blit_req_t q;
        int        kind;
        kind = $urandom_range(99);
        q.src_row = 10'($urandom);
        q.src_col = 10'($urandom);
        q.base = $urandom;
        q.pitch = (kind % 17 == 0) ? 10'd0 : 10'($urandom_range(1023, 1));
        if (kind < 80)
        begin
            q.dest_row = 11'(int'($urandom_range(230)) - 70);
            q.dest_col = 11'(int'($urandom_range(340)) - 90);
            q.height = (kind < 6) ? 7'($urandom_range(127, 65)) : 7'($urandom_range(64, 1));
            q.width = 8'($urandom_range(255, 1));
        end
        else
        begin
            q.dest_row = 11'($urandom);
            q.dest_col = 11'($urandom);
            q.height = 7'($urandom);
            q.width = 8'($urandom);
        end
        return q;
    endfunction

    task automatic send_blit(input blit_req_t q, input int idle_pct);
        int gap;
        gap = 0;
        while (int'($urandom_range(99)) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        dest_row <= q.dest_row;
        dest_col <= q.dest_col;
        src_row <= q.src_row;
        src_col <= q.src_col;
        sprite_height <= q.height;
        sprite_width <= q.width;
        image_base <= q.base;
        image_pitch <= q.pitch;
        do
            @(posedge clk);
        while (!in_ready);
        board.plan_rows(q);
    endtask

    task automatic run_random(input int count, input int idle_pct);
        repeat (count) send_blit(random_blit(), idle_pct);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_frame_base(input logic [31:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.frame_base = value;
    endtask

    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= (int'($urandom_range(99)) >= ready_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_row(source_address, dest_address, halfword_count, last_row);
    end

    initial
    begin
        #12000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        blit_req_t directed_q[$];
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        dest_row = '0;
        dest_col = '0;
        src_row = '0;
        src_col = '0;
        sprite_height = '0;
        sprite_width = '0;
        image_base = '0;
        image_pitch = '0;

        directed_q.push_back(make_blit(5, 3, 2, 3, 3, 7, 32'h0800_0000, 33));
        directed_q.push_back(make_blit(10, 10, 0, 0, 0, 16, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(10, 10, 0, 0, 8, 0, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(10, -20, 0, 0, 8, 20, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(10, 240, 0, 0, 8, 20, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(-8, 10, 0, 0, 8, 20, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(160, 10, 0, 0, 8, 20, 32'h0800_0000, 64));
        directed_q.push_back(make_blit(0, 0, 0, 0, 127, 16, 32'h0800_1000, 100));
        directed_q.push_back(make_blit(20, 50, 4, 9, 65, 31, 32'h0800_2001, 77));
        directed_q.push_back(make_blit(30, 239, 1, 1, 4, 8, 32'h0800_0000, 255));
        directed_q.push_back(make_blit(30, -7, 1, 0, 4, 8, 32'h0800_0000, 255));
        directed_q.push_back(make_blit(40, 40, 3, 5, 4, 20, 32'h0800_0000, 0));
        directed_q.push_back(make_blit(-1024, -1024, 0, 0, 127, 255, 32'hFFFF_FFFF, 1023));
        directed_q.push_back(make_blit(1023, 1023, 1023, 1023, 64, 255, 32'h0, 1));
        directed_q.push_back(make_blit(-63, 100, 0, 0, 64, 12, 32'h0000_0100, 10));
        directed_q.push_back(make_blit(159, 100, 7, 7, 64, 12, 32'h0000_0100, 10));
        directed_q.push_back(make_blit(96, 0, 0, 0, 64, 255, 32'h1234_5678, 512));
        directed_q.push_back(make_blit(0, -15, 0, 0, 3, 255, 32'h0000_0000, 300));
        directed_q.push_back(make_blit(2, 2, 1023, 1023, 5, 9, 32'hFFFF_FFF0, 1023));
        directed_q.push_back(make_blit(-1, -1, 0, 0, 2, 2, 32'h8000_0000, 3));
        directed_q.push_back(make_blit(100, 200, 511, 512, 33, 40, 32'h7FFF_FFFF, 513));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
            send_blit(directed_q[i], 0);
        in_valid <= 1'b0;

        write_frame_base(32'h0000_0000);
        ready_stall_pct = 0;
        run_random(50, 49);

        write_frame_base(32'hFFFF_FFFF);
        ready_stall_pct = 49;
        hold_requests++;
        run_random(50, 0);

        write_frame_base($urandom);
        ready_stall_pct = 38;
        run_random(50, 38);

        write_frame_base($urandom | 32'h1);
        ready_stall_pct = 0;
        run_random(50, 0);

        wait_drained();
        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
